// File: src/rgbctb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbctb_pkg
// Shared types and constants for the RGB color transition blend pipeline.
// ----------------------------------------------------------------------------
package rgbctb_pkg;

	// field widths
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;
	localparam int STEP_W   = 16;
	localparam int DIFF_W   = STEP_W + 1;
	localparam int SDIFF_W  = CHAN_W + 1;
	localparam int THR_W    = DIFF_W + 2;

	// default dither shift
	localparam int unsigned PWM_SHIFT_DEF = 2;

	// divider split: remainder bits and fade quotient bits per stage
	localparam int DIV_STAGES          = 4;
	localparam int PWM_BITS_PER_STAGE  = STEP_W / DIV_STAGES;
	localparam int FADE_BITS_PER_STAGE = CHAN_W / DIV_STAGES;

	// register stages from request to result
	localparam int PIPE_DEPTH = DIV_STAGES + 2;

	typedef enum logic [1:0] {
		MODE_JUMP    = 2'd0,
		MODE_TRIGGER = 2'd1,
		MODE_PWM     = 2'd2,
		MODE_FADE    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CHAN_W-1:0] first_red;
		logic [CHAN_W-1:0] first_green;
		logic [CHAN_W-1:0] first_blue;
		logic [CHAN_W-1:0] second_red;
		logic [CHAN_W-1:0] second_green;
		logic [CHAN_W-1:0] second_blue;
		logic [STEP_W-1:0] segment_start;
		logic [STEP_W-1:0] segment_end;
		logic [STEP_W-1:0] current_step;
		logic [1:0]        transition_mode;
	} in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} out_t;

	// payload carried down the divider stages
	typedef struct packed {
		mode_t                             mode;
		logic [NUM_CHAN-1:0][CHAN_W-1:0]   first;
		logic [NUM_CHAN-1:0][CHAN_W-1:0]   second;
		logic signed [DIFF_W-1:0]          dur;
		logic signed [DIFF_W-1:0]          pos;
		logic                              pos_neg;
		logic [STEP_W-1:0]                 pos_mag;
		logic [STEP_W-1:0]                 pwm_div;
		logic                              pwm_div_zero;
		logic [STEP_W-1:0]                 pwm_rem;
		logic [STEP_W-1:0]                 dur_mag;
		logic                              dur_zero;
		logic [NUM_CHAN-1:0][CHAN_W-1:0]   diff_mag;
		logic [NUM_CHAN-1:0]               quo_neg;
		logic [NUM_CHAN-1:0][STEP_W-1:0]   fade_rem;
		logic [NUM_CHAN-1:0][CHAN_W-1:0]   fade_quo;
	} work_t;

endpackage

// File: src/rgbctb_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbctb_prep
// First stage: segment differences, dither divisor, magnitudes and signs.
// ----------------------------------------------------------------------------
module rgbctb_prep #(
	parameter int unsigned PWM_SHIFT = rgbctb_pkg::PWM_SHIFT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rgbctb_pkg::in_t     req,
	output logic                valid_s1,
	input  logic                next_ready,
	output rgbctb_pkg::work_t   work_s1
);

	rgbctb_pkg::work_t                    work_c;
	logic signed [rgbctb_pkg::DIFF_W-1:0] dur_c;
	logic signed [rgbctb_pkg::DIFF_W-1:0] pos_c;
	logic signed [rgbctb_pkg::DIFF_W-1:0] pwm_m;
	logic [rgbctb_pkg::DIFF_W-1:0]        pwm_m_abs;
	logic [rgbctb_pkg::DIFF_W-1:0]        pos_abs;
	logic [rgbctb_pkg::DIFF_W-1:0]        dur_abs;
	logic signed [rgbctb_pkg::SDIFF_W-1:0] diff_c [rgbctb_pkg::NUM_CHAN];
	logic [rgbctb_pkg::SDIFF_W-1:0]       diff_abs [rgbctb_pkg::NUM_CHAN];

	assign req_ready = !valid_s1 || next_ready;

	// differences against segment start and the floor-shifted divisor
	always_comb begin
		dur_c     = $signed({1'b0, req.segment_end}) - $signed({1'b0, req.segment_start});
		pos_c     = $signed({1'b0, req.current_step}) - $signed({1'b0, req.segment_start});
		pwm_m     = dur_c >>> PWM_SHIFT;
		pwm_m_abs = pwm_m[rgbctb_pkg::DIFF_W-1] ? rgbctb_pkg::DIFF_W'(-pwm_m) : pwm_m;
		pos_abs   = pos_c[rgbctb_pkg::DIFF_W-1] ? rgbctb_pkg::DIFF_W'(-pos_c) : pos_c;
		dur_abs   = dur_c[rgbctb_pkg::DIFF_W-1] ? rgbctb_pkg::DIFF_W'(-dur_c) : dur_c;
	end

	// per-channel signed difference, second minus first
	always_comb begin
		diff_c[0] = $signed({1'b0, req.second_red})   - $signed({1'b0, req.first_red});
		diff_c[1] = $signed({1'b0, req.second_green}) - $signed({1'b0, req.first_green});
		diff_c[2] = $signed({1'b0, req.second_blue})  - $signed({1'b0, req.first_blue});
		for (int c = 0; c < rgbctb_pkg::NUM_CHAN; c++) begin
			diff_abs[c] = diff_c[c][rgbctb_pkg::SDIFF_W-1] ?
				rgbctb_pkg::SDIFF_W'(-diff_c[c]) : diff_c[c];
		end
	end

	// assemble the stage payload with cleared divider state
	always_comb begin
		work_c           = '0;
		work_c.mode      = rgbctb_pkg::mode_t'(req.transition_mode);
		work_c.first[0]  = req.first_red;
		work_c.first[1]  = req.first_green;
		work_c.first[2]  = req.first_blue;
		work_c.second[0] = req.second_red;
		work_c.second[1] = req.second_green;
		work_c.second[2] = req.second_blue;
		work_c.dur       = dur_c;
		work_c.pos       = pos_c;
		work_c.pos_neg   = pos_c[rgbctb_pkg::DIFF_W-1];
		work_c.pos_mag   = pos_abs[rgbctb_pkg::STEP_W-1:0];
		work_c.pwm_div   = pwm_m_abs[rgbctb_pkg::STEP_W-1:0];
		work_c.pwm_div_zero = (pwm_m == '0);
		work_c.dur_mag   = dur_abs[rgbctb_pkg::STEP_W-1:0];
		work_c.dur_zero  = (dur_c == '0);
		for (int c = 0; c < rgbctb_pkg::NUM_CHAN; c++) begin
			work_c.diff_mag[c] = diff_abs[c][rgbctb_pkg::CHAN_W-1:0];
			work_c.quo_neg[c]  = diff_c[c][rgbctb_pkg::SDIFF_W-1] ^ dur_c[rgbctb_pkg::DIFF_W-1];
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			work_s1 <= work_c;
		end
	end

endmodule

// File: src/rgbctb_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbctb_div_step
// One slice of the restoring dividers: remainder bits for the dither
// divisor and quotient bits for the three fade channels.
// ----------------------------------------------------------------------------
module rgbctb_div_step #(
	parameter int STAGE = 0
) (
	input  rgbctb_pkg::work_t  in_work,
	output rgbctb_pkg::work_t  out_work
);

	localparam int PWM_TOP  = rgbctb_pkg::STEP_W - 1 - STAGE * rgbctb_pkg::PWM_BITS_PER_STAGE;
	localparam int FADE_TOP = rgbctb_pkg::CHAN_W - 1 - STAGE * rgbctb_pkg::FADE_BITS_PER_STAGE;

	// remainder of |position| by |m|, a few bits per stage
	// quotient of |channel diff| by |duration|, a few bits per stage
	always_comb begin
		logic [rgbctb_pkg::STEP_W:0] t;
		out_work = in_work;
		for (int j = 0; j < rgbctb_pkg::PWM_BITS_PER_STAGE; j++) begin
			t = {out_work.pwm_rem, out_work.pos_mag[PWM_TOP - j]};
			if (t >= {1'b0, out_work.pwm_div}) begin
				out_work.pwm_rem = rgbctb_pkg::STEP_W'(t - {1'b0, out_work.pwm_div});
			end else begin
				out_work.pwm_rem = t[rgbctb_pkg::STEP_W-1:0];
			end
		end
		for (int c = 0; c < rgbctb_pkg::NUM_CHAN; c++) begin
			for (int j = 0; j < rgbctb_pkg::FADE_BITS_PER_STAGE; j++) begin
				t = {out_work.fade_rem[c], out_work.diff_mag[c][FADE_TOP - j]};
				if (t >= {1'b0, out_work.dur_mag}) begin
					out_work.fade_rem[c] = rgbctb_pkg::STEP_W'(t - {1'b0, out_work.dur_mag});
					out_work.fade_quo[c] = {out_work.fade_quo[c][rgbctb_pkg::CHAN_W-2:0], 1'b1};
				end else begin
					out_work.fade_rem[c] = t[rgbctb_pkg::STEP_W-1:0];
					out_work.fade_quo[c] = {out_work.fade_quo[c][rgbctb_pkg::CHAN_W-2:0], 1'b0};
				end
			end
		end
	end

endmodule

// File: src/rgbctb_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbctb_finish
// Last stage: dither threshold compare, fade multiply-add, mode select
// and the result register.
// ----------------------------------------------------------------------------
module rgbctb_finish #(
	parameter int unsigned PWM_SHIFT = rgbctb_pkg::PWM_SHIFT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                work_valid,
	output logic                work_ready,
	input  rgbctb_pkg::work_t   work,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rgbctb_pkg::out_t    rsp
);

	logic signed [rgbctb_pkg::DIFF_W-1:0] rem_s;
	logic signed [rgbctb_pkg::THR_W-1:0]  thr;
	logic                                 pwm_hit;
	logic [rgbctb_pkg::CHAN_W-1:0]        quo_s [rgbctb_pkg::NUM_CHAN];
	logic [2*rgbctb_pkg::CHAN_W-1:0]      prod [rgbctb_pkg::NUM_CHAN];
	logic [rgbctb_pkg::NUM_CHAN-1:0][rgbctb_pkg::CHAN_W-1:0] fade_c;
	logic [rgbctb_pkg::NUM_CHAN-1:0][rgbctb_pkg::CHAN_W-1:0] color_c;
	logic                                 valid_s6;
	rgbctb_pkg::out_t                     data_s6;

	assign work_ready = !valid_s6 || rsp_ready;
	assign rsp_valid  = valid_s6;
	assign rsp        = data_s6;

	// signed remainder and dither threshold
	always_comb begin
		if (work.pwm_div_zero) begin
			rem_s = '0;
		end else if (work.pos_neg) begin
			rem_s = rgbctb_pkg::DIFF_W'(-$signed({1'b0, work.pwm_rem}));
		end else begin
			rem_s = $signed({1'b0, work.pwm_rem});
		end
		thr     = rgbctb_pkg::THR_W'(work.dur) - (rgbctb_pkg::THR_W'(rem_s) <<< PWM_SHIFT);
		pwm_hit = rgbctb_pkg::THR_W'(work.pos) > thr;
	end

	// fade: first plus signed quotient times position, low byte only
	always_comb begin
		for (int c = 0; c < rgbctb_pkg::NUM_CHAN; c++) begin
			quo_s[c]  = work.quo_neg[c] ? rgbctb_pkg::CHAN_W'(-work.fade_quo[c]) :
				work.fade_quo[c];
			prod[c]   = {{rgbctb_pkg::CHAN_W{1'b0}}, quo_s[c]} *
				{{rgbctb_pkg::CHAN_W{1'b0}}, work.pos[rgbctb_pkg::CHAN_W-1:0]};
			fade_c[c] = rgbctb_pkg::CHAN_W'(work.first[c] + prod[c][rgbctb_pkg::CHAN_W-1:0]);
		end
	end

	// mode select
	always_comb begin
		case (work.mode)
			rgbctb_pkg::MODE_PWM:  color_c = pwm_hit ? work.second : work.first;
			rgbctb_pkg::MODE_FADE: color_c = work.dur_zero ? work.first : fade_c;
			default:               color_c = work.first;
		endcase
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (work_ready) begin
			valid_s6 <= work_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (work_valid && work_ready) begin
			data_s6.out_red   <= color_c[0];
			data_s6.out_green <= color_c[1];
			data_s6.out_blue  <= color_c[2];
		end
	end

endmodule

// File: src/rgb_color_transition_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_transition_blend
// Blends two RGB888 colors by position within a segment: jump, trigger,
// dither and linear fade modes.
// ----------------------------------------------------------------------------
//  channel   signals                    payload
//  request   req_valid / req_ready      req (rgbctb_pkg::in_t)
//  result    rsp_valid / rsp_ready      rsp (rgbctb_pkg::out_t)
//
//  Six register stages: setup, four divider stages, then multiply-add and
//  select into the result register. One request per cycle unless the
//  result stalls. The divider depth (16 remainder bits at four per stage)
//  sets the stage count. Reset clears only the stage valid bits. Each stage
//  fills whenever it is empty or its successor moves, so bubbles close up
//  and a stalled result holds without loss while earlier stages keep filling.
// ----------------------------------------------------------------------------
module rgb_color_transition_blend #(
	parameter int unsigned PWM_SHIFT = rgbctb_pkg::PWM_SHIFT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rgbctb_pkg::in_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rgbctb_pkg::out_t  rsp
);

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic              rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	rgbctb_pkg::work_t work_s1, work_s2, work_s3, work_s4, work_s5;
	rgbctb_pkg::work_t step1_c, step2_c, step3_c, step4_c;

	// setup stage
	rgbctb_prep #(
		.PWM_SHIFT (PWM_SHIFT)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.valid_s1   (valid_s1),
		.next_ready (rdy_s2),
		.work_s1    (work_s1)
	);

	// divider slices
	rgbctb_div_step #(.STAGE(0)) u_div0 (.in_work(work_s1), .out_work(step1_c));
	rgbctb_div_step #(.STAGE(1)) u_div1 (.in_work(work_s2), .out_work(step2_c));
	rgbctb_div_step #(.STAGE(2)) u_div2 (.in_work(work_s3), .out_work(step3_c));
	rgbctb_div_step #(.STAGE(3)) u_div3 (.in_work(work_s4), .out_work(step4_c));

	// stage ready chain
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s4 = !valid_s4 || rdy_s5;
	assign rdy_s5 = !valid_s5 || rdy_s6;

	// divider stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	// divider stage payloads
	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) work_s2 <= step1_c;
		if (rdy_s3 && valid_s2) work_s3 <= step2_c;
		if (rdy_s4 && valid_s3) work_s4 <= step3_c;
		if (rdy_s5 && valid_s4) work_s5 <= step4_c;
	end

	// select and result register
	rgbctb_finish #(
		.PWM_SHIFT (PWM_SHIFT)
	) u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (valid_s5),
		.work_ready (rdy_s6),
		.work       (work_s5),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

// File: src/rgbctb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbctb_checker
// Port-level checks: result hold under stall, request/result balance and
// pipeline occupancy.
// ----------------------------------------------------------------------------
module rgbctb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input rgbctb_pkg::in_t   req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input rgbctb_pkg::out_t  rsp
);

	localparam int CNT_W = $clog2(rgbctb_pkg::PIPE_DEPTH + 1);

	logic             req_fire;
	logic             rsp_fire;
	logic [CNT_W-1:0] inflight_q;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (req_fire && !rsp_fire) begin
			inflight_q <= CNT_W'(inflight_q + 1'b1);
		end else if (!req_fire && rsp_fire) begin
			inflight_q <= CNT_W'(inflight_q - 1'b1);
		end
	end

	// stalled result holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// no result without an outstanding request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> inflight_q != '0)
		else $error("result without request");

	// occupancy never exceeds the stage count
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(rgbctb_pkg::PIPE_DEPTH))
		else $error("more requests in flight than stages");

	// an empty pipeline takes requests
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> req_ready)
		else $error("empty pipeline refused request");

endmodule

bind rgb_color_transition_blend rgbctb_checker u_rgbctb_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_color_transition_blend: directed corner
// requests then random segments across all four modes, random idling on
// both channels, and every result compared against a local color model.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SHIFT       = rgbctb_pkg::PWM_SHIFT_DEF;
	localparam int NUM_RANDOM  = 600;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = rgbctb_pkg::PIPE_DEPTH + 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	rgbctb_pkg::in_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rgbctb_pkg::out_t rsp;

	rgbctb_pkg::in_t req_queue[$];
	rgbctb_pkg::out_t color_queue[$];
	int err_cnt = 0;
	int sent_cnt = 0;
	int got_cnt = 0;
	int stall_cycles = 0;
	int mode_cnt[4] = '{0, 0, 0, 0};

	rgb_color_transition_blend u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// expected color for one request
	function automatic rgbctb_pkg::out_t blend_color(rgbctb_pkg::in_t r);
		int dur;
		int pos;
		int m;
		int rem;
		int diff;
		int q;
		longint thr;
		longint v;
		logic [7:0] a[3];
		logic [7:0] b[3];
		logic [7:0] o[3];
		rgbctb_pkg::out_t res;
		a[0] = r.first_red;
		a[1] = r.first_green;
		a[2] = r.first_blue;
		b[0] = r.second_red;
		b[1] = r.second_green;
		b[2] = r.second_blue;
		o = a;
		dur = int'(r.segment_end) - int'(r.segment_start);
		pos = int'(r.current_step) - int'(r.segment_start);
		case (rgbctb_pkg::mode_t'(r.transition_mode))
			rgbctb_pkg::MODE_PWM: begin
				// floor shift, remainder takes the sign of position
				m = dur >>> SHIFT;
				rem = (m == 0) ? 0 : pos % m;
				thr = longint'(dur) - (longint'(1) << SHIFT) * longint'(rem);
				if (longint'(pos) > thr)
					o = b;
			end
			rgbctb_pkg::MODE_FADE: begin
				if (dur != 0) begin
					for (int i = 0; i < 3; i++) begin
						diff = int'(b[i]) - int'(a[i]);
						q = diff / dur;
						v = longint'(a[i]) + longint'(q) * longint'(pos);
						o[i] = v[7:0];
					end
				end
			end
			default: ;
		endcase
		res.out_red = o[0];
		res.out_green = o[1];
		res.out_blue = o[2];
		return res;
	endfunction

	function automatic rgbctb_pkg::in_t make_req(int fr, int fg, int fb, int sr, int sg,
			int sb, int seg_start, int seg_end, int step, rgbctb_pkg::mode_t mode);
		rgbctb_pkg::in_t r;
		r.first_red = 8'(fr);
		r.first_green = 8'(fg);
		r.first_blue = 8'(fb);
		r.second_red = 8'(sr);
		r.second_green = 8'(sg);
		r.second_blue = 8'(sb);
		r.segment_start = 16'(seg_start);
		r.segment_end = 16'(seg_end);
		r.current_step = 16'(step);
		r.transition_mode = mode;
		return r;
	endfunction

	// channel value biased toward the extremes
	function automatic int rand_chan();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_ready) begin
			if (req_queue.size() != 0 &&
					((sent_cnt >= 250 && sent_cnt < 400) || $urandom_range(0, 99) >= 17)) begin
				req <= req_queue.pop_front();
				req_valid <= 1'b1;
				sent_cnt++;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// record accepted requests, check results, random result stalls
	always @(posedge clk) begin : color_check
		rgbctb_pkg::out_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				color_queue.push_back(blend_color(req));
				mode_cnt[req.transition_mode]++;
			end
			if (rsp_valid && rsp_ready) begin
				got_cnt++;
				if (color_queue.size() == 0) begin
					report_mismatch("unexpected result red", rsp.out_red, 0);
				end else begin
					want = color_queue.pop_front();
					if (rsp.out_red !== want.out_red)
						report_mismatch("out_red", rsp.out_red, want.out_red);
					if (rsp.out_green !== want.out_green)
						report_mismatch("out_green", rsp.out_green, want.out_green);
					if (rsp.out_blue !== want.out_blue)
						report_mismatch("out_blue", rsp.out_blue, want.out_blue);
				end
			end
			rsp_ready <= (got_cnt >= 250 && got_cnt < 400) || $urandom_range(0, 99) >= 17;
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("FAIL rgb_color_transition_blend");
			$finish;
		end
	end

	initial begin
		int seg_start;
		int len;
		int off;
		// directed: pass-through modes at the extremes
		req_queue.push_back(make_req(255, 0, 255, 0, 255, 0, 0, 65535, 65535,
			rgbctb_pkg::MODE_JUMP));
		req_queue.push_back(make_req(0, 255, 0, 255, 0, 255, 0, 65535, 0,
			rgbctb_pkg::MODE_TRIGGER));
		req_queue.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, rgbctb_pkg::MODE_JUMP));
		req_queue.push_back(make_req(255, 255, 255, 255, 255, 255, 65535, 65535, 65535,
			rgbctb_pkg::MODE_TRIGGER));
		// dither: mid segment, zero duration, zero divisor, reversed and outside
		req_queue.push_back(make_req(10, 20, 30, 200, 210, 220, 0, 100, 50,
			rgbctb_pkg::MODE_PWM));
		req_queue.push_back(make_req(10, 20, 30, 200, 210, 220, 10, 10, 20,
			rgbctb_pkg::MODE_PWM));
		req_queue.push_back(make_req(1, 2, 3, 250, 251, 252, 100, 103, 105,
			rgbctb_pkg::MODE_PWM));
		req_queue.push_back(make_req(1, 2, 3, 250, 251, 252, 1000, 100, 500,
			rgbctb_pkg::MODE_PWM));
		req_queue.push_back(make_req(1, 2, 3, 250, 251, 252, 500, 1000, 10,
			rgbctb_pkg::MODE_PWM));
		req_queue.push_back(make_req(0, 0, 0, 255, 255, 255, 0, 65535, 65535,
			rgbctb_pkg::MODE_PWM));
		req_queue.push_back(make_req(0, 0, 0, 255, 255, 255, 0, 64, 64,
			rgbctb_pkg::MODE_PWM));
		req_queue.push_back(make_req(0, 0, 0, 255, 255, 255, 65535, 0, 0,
			rgbctb_pkg::MODE_PWM));
		req_queue.push_back(make_req(9, 8, 7, 6, 5, 4, 300, 100, 400, rgbctb_pkg::MODE_PWM));
		// fade: zero duration, up, down, truncation to zero, wrap, reversed
		req_queue.push_back(make_req(12, 34, 56, 200, 100, 0, 77, 77, 90,
			rgbctb_pkg::MODE_FADE));
		req_queue.push_back(make_req(0, 0, 0, 255, 255, 255, 0, 255, 128,
			rgbctb_pkg::MODE_FADE));
		req_queue.push_back(make_req(255, 200, 100, 0, 0, 0, 0, 7, 3,
			rgbctb_pkg::MODE_FADE));
		req_queue.push_back(make_req(0, 100, 255, 200, 0, 254, 0, 65535, 40000,
			rgbctb_pkg::MODE_FADE));
		req_queue.push_back(make_req(0, 128, 255, 255, 0, 0, 300, 100, 200,
			rgbctb_pkg::MODE_FADE));
		req_queue.push_back(make_req(0, 0, 0, 255, 255, 255, 0, 1, 65535,
			rgbctb_pkg::MODE_FADE));
		req_queue.push_back(make_req(5, 50, 150, 250, 10, 100, 60000, 60010, 0,
			rgbctb_pkg::MODE_FADE));
		req_queue.push_back(make_req(255, 255, 0, 0, 0, 255, 0, 1, 65535,
			rgbctb_pkg::MODE_FADE));
		req_queue.push_back(make_req(0, 255, 0, 255, 0, 255, 65535, 0, 0,
			rgbctb_pkg::MODE_FADE));
		// random segments, mostly short with the step near the segment
		repeat (NUM_RANDOM) begin
			if ($urandom_range(0, 9) < 2) begin
				req_queue.push_back(make_req($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom,
					rgbctb_pkg::mode_t'($urandom_range(0, 3))));
			end else begin
				seg_start = $urandom_range(0, 65535);
				case ($urandom_range(0, 9))
					0, 1: len = $urandom_range(0, 3);
					2, 3, 4, 5: len = $urandom_range(0, 64);
					6, 7: len = $urandom_range(0, 1024);
					8: len = $urandom_range(0, 65535);
					default: len = -int'($urandom_range(1, 1024));
				endcase
				if ($urandom_range(0, 4) == 0)
					off = $urandom_range(0, 65535);
				else if (len >= 0)
					off = $urandom_range(0, len);
				else
					off = -int'($urandom_range(0, -len));
				req_queue.push_back(make_req(rand_chan(), rand_chan(), rand_chan(),
					rand_chan(), rand_chan(), rand_chan(), seg_start, seg_start + len,
					seg_start + off, rgbctb_pkg::mode_t'($urandom_range(0, 3))));
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait until everything is sent and answered, then let the pipe drain
		while (req_queue.size() != 0 || req_valid || color_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d colors: %0d jump, %0d trigger, %0d dither, %0d fade",
			got_cnt, mode_cnt[rgbctb_pkg::MODE_JUMP], mode_cnt[rgbctb_pkg::MODE_TRIGGER],
			mode_cnt[rgbctb_pkg::MODE_PWM], mode_cnt[rgbctb_pkg::MODE_FADE]);
		$display("mismatches seen: %0d", err_cnt);
		if (err_cnt == 0)
			$display("PASS rgb_color_transition_blend");
		else
			$display("FAIL rgb_color_transition_blend");
		$finish;
	end

endmodule
